### sv/c3rb_pkg.sv
package c3rb_pkg;

  // Default line-store depth and image height limit.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Smallest image side that the window logic handles.
  localparam int MIN_SIZE = 3;

  // Field widths.
  localparam int PIX_W       = 16;
  localparam int ROW_W       = 3 * PIX_W;
  localparam int SIZE_W      = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int RES_W       = 23;
  localparam int OUT_TDATA_W = 24;

  // Arithmetic widths: one product, a sum of three, a sum of nine.
  localparam int FRAC_BITS  = 12;
  localparam int PROD_W     = 2 * PIX_W;
  localparam int RSUM_W     = PROD_W + 2;
  localparam int SUM_W      = PROD_W + 4;
  localparam int ROUND_HALF = 2048;

  // Register reset values.
  localparam logic [ROW_W-1:0]  COEF_TOP_RST = '0;
  localparam logic [ROW_W-1:0]  COEF_MID_RST = ROW_W'(48'h0000_1000_0000);
  localparam logic [ROW_W-1:0]  COEF_BOT_RST = '0;
  localparam logic [SIZE_W-1:0] WIDTH_RST    = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] HEIGHT_RST   = SIZE_W'(1024);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_TOP = 3'd0,
    CFG_COEF_MID = 3'd1,
    CFG_COEF_BOT = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_HEIGHT   = 3'd4
  } cfg_idx_t;

  // Item kinds carried on in_tuser.
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // Window stage phases: push a new column, then the right-border repeat.
  typedef enum logic {
    PH_PUSH  = 1'b0,
    PH_RIGHT = 1'b1
  } win_ph_t;

  typedef logic signed [PIX_W-1:0] pix_t;

  // 3x3 block, index [row][col], row 0 = top, col 0 = left.
  typedef pix_t [2:0][2:0] win_t;

  // Per-item control handed from the position tracker to the window stage.
  typedef struct packed {
    logic is_pixel;
    logic first;
    logic rowone;
    logic emit_col;
    logic emit_right;
    logic last;
    pix_t px;
  } item_ctl_t;

endpackage

### sv/conv3x3_replicate_border_core.sv
// Channel  Handshake               Payload
// in_      in_tvalid / in_tready   in_tdata = pixel_value, in_tuser = opcode
// out_     out_tvalid / out_tready out_tdata = result_value, out_tlast = last_of_frame
// cfg_     cfg_valid / cfg_ready   cfg_index = register index, cfg_data = value
//
// One item is taken per clock while the window stage is ready. An item that closes
// an image row after the first, or the last drain item, holds the window stage in its
// right-border phase for a second result. Results leave through the capture, product,
// row-sum and output registers. Reset (rst_n low, synchronous) clears the positions,
// the window and all valid flags; the line stores are not cleared. Output stalls back
// up the elastic pipeline, so input keeps flowing until every stage is full.
module conv3x3_replicate_border_core import c3rb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PIX_W-1:0]       in_tdata,    // [15:0] pixel_value
  input  logic [0:0]             in_tuser,    // [0] opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [22:0] result_value, [23] zero
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [ROW_W-1:0]  coef_top_r, coef_mid_r, coef_bot_r;
  logic [SIZE_W-1:0] width_r, height_r;
  logic              issue_valid, win_ready, wr_en, mac_valid, mac_ready, mac_last;
  item_ctl_t         issue_ctl;
  logic [AW-1:0]     issue_addr, wr_addr;
  pix_t              rd_older, rd_newer, wr_older, wr_newer;
  win_t              mac_win, coef;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_top_r <= COEF_TOP_RST;
      coef_mid_r <= COEF_MID_RST;
      coef_bot_r <= COEF_BOT_RST;
      width_r    <= WIDTH_RST;
      height_r   <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COEF_TOP: coef_top_r <= cfg_data[ROW_W-1:0];
        CFG_COEF_MID: coef_mid_r <= cfg_data[ROW_W-1:0];
        CFG_COEF_BOT: coef_bot_r <= cfg_data[ROW_W-1:0];
        CFG_WIDTH:    width_r    <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT:   height_r   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign coef = win_t'({coef_bot_r, coef_mid_r, coef_top_r});

  // Raster position tracking and line-store read issue.
  c3rb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_width   (width_r),
    .cfg_height  (height_r),
    .win_ready   (win_ready),
    .issue_valid (issue_valid),
    .issue_ctl   (issue_ctl),
    .issue_addr  (issue_addr)
  );

  // Line stores: the two most recent complete rows.
  c3rb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_older (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_older),
    .re    (issue_valid),
    .raddr (issue_addr),
    .rdata (rd_older)
  );

  c3rb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_newer (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_newer),
    .re    (issue_valid),
    .raddr (issue_addr),
    .rdata (rd_newer)
  );

  // Window update and line-store write-back.
  c3rb_win #(
    .AW (AW)
  ) u_win (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue_valid (issue_valid),
    .issue_ctl   (issue_ctl),
    .issue_addr  (issue_addr),
    .rd_older    (rd_older),
    .rd_newer    (rd_newer),
    .win_ready   (win_ready),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_older    (wr_older),
    .wr_newer    (wr_newer),
    .mac_ready   (mac_ready),
    .mac_valid   (mac_valid),
    .mac_win     (mac_win),
    .mac_last    (mac_last)
  );

  // Multiply-accumulate pipeline and output register.
  c3rb_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .coef       (coef),
    .in_valid   (mac_valid),
    .in_ready   (mac_ready),
    .in_win     (mac_win),
    .in_last    (mac_last),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### sv/c3rb_ram.sv
module c3rb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds when idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/c3rb_ctrl.sv
module c3rb_ctrl import c3rb_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [PIX_W-1:0]              in_tdata,
  input  logic [0:0]                    in_tuser,
  input  logic [SIZE_W-1:0]             cfg_width,
  input  logic [SIZE_W-1:0]             cfg_height,
  input  logic                          win_ready,
  output logic                          issue_valid,
  output item_ctl_t                     issue_ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]  issue_addr
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [AW-1:0] col_r, col_nxt, drn_r, drn_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [AW-1:0] w_last, col_s, drn_s, pos;
  logic [HW-1:0] row_s;
  logic          is_drain, frame_full, item_ok, at_end, has_row, in_fire;

  // Clamp the configured sizes to the supported range.
  always_comb begin
    if (32'(cfg_width) < 32'(MIN_SIZE)) begin
      w_eff = WW'(MIN_SIZE);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width);
    end
    if (32'(cfg_height) < 32'(MIN_SIZE)) begin
      h_eff = HW'(MIN_SIZE);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height);
    end
  end

  // Positions saturate to the current image size.
  always_comb begin
    w_last     = AW'(w_eff - WW'(1));
    col_s      = (col_r > w_last) ? w_last : col_r;
    drn_s      = (drn_r > w_last) ? w_last : drn_r;
    row_s      = (row_r > h_eff) ? h_eff : row_r;
    is_drain   = (op_t'(in_tuser[0]) == OP_DRAIN);
    frame_full = (row_s == h_eff);
    item_ok    = is_drain ? frame_full : !frame_full;
    pos        = is_drain ? drn_s : col_s;
    at_end     = (pos == w_last);
    has_row    = (row_s != '0);
  end

  // Control word for the window stage and the line-store read address.
  always_comb begin
    issue_ctl.is_pixel   = !is_drain;
    issue_ctl.first      = (pos == '0);
    issue_ctl.rowone     = !is_drain && (row_s == HW'(1));
    issue_ctl.emit_col   = has_row && (pos != '0);
    issue_ctl.emit_right = has_row && at_end;
    issue_ctl.last       = is_drain && at_end;
    issue_ctl.px         = pix_t'(in_tdata);
    issue_addr           = pos;
  end

  assign in_tready   = win_ready;
  assign in_fire     = in_tvalid && in_tready;
  assign issue_valid = in_fire && item_ok;

  // Advance the raster and drain positions for each effective item.
  always_comb begin
    col_nxt = col_s;
    row_nxt = row_s;
    drn_nxt = drn_s;
    if (item_ok) begin
      if (is_drain) begin
        if (at_end) begin
          col_nxt = '0;
          row_nxt = '0;
          drn_nxt = '0;
        end else begin
          drn_nxt = pos + AW'(1);
        end
      end else if (at_end) begin
        col_nxt = '0;
        row_nxt = row_s + HW'(1);
      end else begin
        col_nxt = pos + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      drn_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      drn_r <= drn_nxt;
    end
  end

endmodule

### sv/c3rb_win.sv
module c3rb_win import c3rb_pkg::*; #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          issue_valid,
  input  item_ctl_t     issue_ctl,
  input  logic [AW-1:0] issue_addr,
  input  pix_t          rd_older,
  input  pix_t          rd_newer,
  output logic          win_ready,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output pix_t          wr_older,
  output pix_t          wr_newer,
  input  logic          mac_ready,
  output logic          mac_valid,
  output win_t          mac_win,
  output logic          mac_last
);

  logic          b_valid_r;
  item_ctl_t     b_ctl_r;
  logic [AW-1:0] b_addr_r;
  win_ph_t       ph_r, ph_nxt;
  win_t          win_r, pushed, replic, win_nxt;
  pix_t [2:0]    col_v;
  logic          emit, step, two_step, b_done;

  // New column from the line stores; top row repeats at the first row.
  always_comb begin
    col_v[0] = b_ctl_r.rowone ? rd_newer : rd_older;
    col_v[1] = rd_newer;
    col_v[2] = b_ctl_r.is_pixel ? b_ctl_r.px : rd_newer;
  end

  // Shift the window left, or seed it at the left border.
  always_comb begin
    pushed = win_r;
    replic = win_r;
    for (int r = 0; r < 3; r++) begin
      if (b_ctl_r.first) begin
        pushed[r][1] = col_v[r];
      end else begin
        pushed[r][0] = win_r[r][1];
        pushed[r][1] = win_r[r][2];
      end
      pushed[r][2] = col_v[r];
      replic[r][0] = win_r[r][1];
      replic[r][1] = win_r[r][2];
    end
  end

  // Next phase: an item that closes a row after the first, or the last drain item, moves on to PH_RIGHT.
  always_comb begin
    ph_nxt = ph_r;
    if (step) begin
      ph_nxt = two_step ? PH_RIGHT : PH_PUSH;
    end
  end

  // Outputs of the phase logic.
  always_comb begin
    case (ph_r)
      PH_PUSH: begin
        emit     = b_ctl_r.emit_col;
        mac_last = 1'b0;
        two_step = b_ctl_r.emit_right;
        win_nxt  = pushed;
      end
      PH_RIGHT: begin
        emit     = 1'b1;
        mac_last = b_ctl_r.last;
        two_step = 1'b0;
        win_nxt  = replic;
      end
      default: begin
        emit     = 1'b0;
        mac_last = 1'b0;
        two_step = 1'b0;
        win_nxt  = win_r;
      end
    endcase
    step      = b_valid_r && (!emit || mac_ready);
    b_done    = step && !two_step;
    win_ready = !b_valid_r || b_done;
    mac_valid = step && emit;
    mac_win   = win_nxt;
    wr_en     = step && (ph_r == PH_PUSH) && b_ctl_r.is_pixel;
    wr_addr   = b_addr_r;
    wr_older  = rd_newer;
    wr_newer  = b_ctl_r.px;
  end

  // Control registers of the window stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      ph_r      <= PH_PUSH;
      win_r     <= '0;
    end else begin
      ph_r <= ph_nxt;
      if (win_ready) begin
        b_valid_r <= issue_valid;
      end
      if (step) begin
        win_r <= win_nxt;
      end
    end
  end

  // Item payload, loaded together with the line-store read.
  always_ff @(posedge clk) begin
    if (win_ready) begin
      b_ctl_r  <= issue_ctl;
      b_addr_r <= issue_addr;
    end
  end

endmodule

### sv/c3rb_mac.sv
module c3rb_mac import c3rb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  win_t                   coef,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  win_t                   in_win,
  input  logic                   in_last,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  logic                     c_v_r, p_v_r, q_v_r, o_v_r;
  logic                     c_rdy, p_rdy, q_rdy, o_rdy;
  win_t                     c_win_r;
  logic                     c_last_r, p_last_r, q_last_r, o_last_r;
  logic signed [PROD_W-1:0] p_r [3][3];
  logic signed [RSUM_W-1:0] q_r [3];
  logic signed [SUM_W-1:0]  sum_all;
  logic [RES_W-1:0]         o_res_r;

  // Each stage moves when it is empty or its successor moves.
  always_comb begin
    o_rdy    = !o_v_r || out_tready;
    q_rdy    = !q_v_r || o_rdy;
    p_rdy    = !p_v_r || q_rdy;
    c_rdy    = !c_v_r || p_rdy;
    in_ready = c_rdy;
  end

  // Final sum of the three row sums plus the rounding half.
  always_comb begin
    sum_all = SUM_W'(q_r[0]) + SUM_W'(q_r[1]) + SUM_W'(q_r[2]) + SUM_W'(ROUND_HALF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      p_v_r <= 1'b0;
      q_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (c_rdy) c_v_r <= in_valid;
      if (p_rdy) p_v_r <= c_v_r;
      if (q_rdy) q_v_r <= p_v_r;
      if (o_rdy) o_v_r <= q_v_r;
    end
  end

  // Window capture, nine products, row sums, rounded result.
  always_ff @(posedge clk) begin
    if (c_rdy) begin
      c_win_r  <= in_win;
      c_last_r <= in_last;
    end
    if (p_rdy) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_r[r][c] <= $signed(c_win_r[r][c]) * $signed(coef[r][c]);
        end
      end
      p_last_r <= c_last_r;
    end
    if (q_rdy) begin
      for (int r = 0; r < 3; r++) begin
        q_r[r] <= RSUM_W'(p_r[r][0]) + RSUM_W'(p_r[r][1]) + RSUM_W'(p_r[r][2]);
      end
      q_last_r <= p_last_r;
    end
    if (o_rdy) begin
      o_res_r  <= sum_all[FRAC_BITS+RES_W-1:FRAC_BITS];
      o_last_r <= q_last_r;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {(OUT_TDATA_W-RES_W)'(0), o_res_r};
  assign out_tlast  = o_last_r;

endmodule

### sv/c3rb_chk.sv
module c3rb_chk import c3rb_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   cfg_ready
);

  // A stalled result holds its value and its frame flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Reset empties the pipeline and leaves the input open.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // The pad bit above the result stays zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1] == 1'b0)
    else $error("result pad bit set");

  // Configuration writes are never held off.
  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind conv3x3_replicate_border_core c3rb_chk u_c3rb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_ready  (cfg_ready)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import c3rb_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int QUIET_CYCLES  = 20;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_EARLY    = 30;
  localparam int RANDOM_ITEMS  = 330;
  localparam int PRESS_W       = 12;
  localparam int PRESS_H       = 6;
  localparam int PRESS_HOLD_AT = 10;

  typedef struct {
    op_t  op;
    pix_t px;
  } item_t;

  typedef struct {
    logic [RES_W-1:0] value;
    logic             is_last;
  } filtered_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [PIX_W-1:0]       in_tdata   = '0;    // [15:0] pixel_value
  logic [0:0]             in_tuser   = '0;    // [0] opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;          // [22:0] result_value, [23] zero
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  conv3x3_replicate_border_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Stimulus and expected results.
  item_t     stream_q[$];
  filtered_t filtered_q[$];

  // Handshake bookkeeping and run statistics.
  logic        in_fired    = 1'b0;
  logic        out_fired   = 1'b0;
  bit          in_idle_on  = 1'b1;
  bit          out_idle_on = 1'b1;
  int          in_gap      = 0;
  int          out_stall   = 0;
  int          hold_left   = 0;
  int          hold_mark   = -1;
  int          cycle_cnt   = 0;
  int          items_in    = 0;
  int          results_seen = 0;
  int          mismatches  = 0;
  int          random_items = 0;
  int          images_sent = 0;
  int          cfg_writes  = 0;
  int unsigned safe_width  = 0;
  item_t       drv_item;

  // Filter state mirrored from the block: mask, sizes, line stores, window.
  logic [ROW_W-1:0]  coef_row [3];
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  pix_t              line_old [MAX_WIDTH_DEF];
  pix_t              line_new [MAX_WIDTH_DEF];
  pix_t              win [3][3];
  int unsigned       row_pos;
  int unsigned       col_pos;
  int unsigned       drain_pos;

  initial begin
    forever #5 clk = ~clk;
  end

  // Effective image side: below three acts as three, above the cap as the cap.
  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned cap);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > cap) return cap;
    return v;
  endfunction

  // Shift a new column into the window; the first column of a row fills
  // both the centre and the right column so the left border replicates.
  function automatic void push_column(pix_t t, pix_t m, pix_t b, bit first_col);
    pix_t v [3];
    v[0] = t;
    v[1] = m;
    v[2] = b;
    for (int r = 0; r < 3; r++) begin
      if (first_col) begin
        win[r][1] = v[r];
      end else begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[r][2] = v[r];
    end
  endfunction

  // Right border: the rightmost column stays and is repeated.
  function automatic void shift_window();
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
  endfunction

  // Apply the mask to the window and round from Q12, half up.
  function automatic void emit_filtered(bit is_last);
    longint    acc;
    filtered_t res;
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc += longint'($signed(coef_row[r][16*c +: 16])) * longint'(win[r][c]);
      end
    end
    res.value   = RES_W'((acc + ROUND_HALF) >>> FRAC_BITS);
    res.is_last = is_last;
    filtered_q.push_back(res);
  endfunction

  // Work out the filtered pixels that one accepted item releases.
  function automatic void filter_item(op_t op, pix_t px);
    int unsigned w, h, r, c, d;
    pix_t        older, newer, top;
    w = eff_size(width_reg, MAX_WIDTH_DEF);
    h = eff_size(height_reg, MAX_HEIGHT_DEF);
    // A size shrunk mid-image saturates the positions.
    if (col_pos > w - 1) col_pos = w - 1;
    if (drain_pos > w - 1) drain_pos = w - 1;
    if (row_pos > h) row_pos = h;
    if (op == OP_PIXEL) begin
      // Pixels after the final row wait for the drain and do nothing.
      if (row_pos < h) begin
        c = col_pos;
        r = row_pos;
        older = line_old[c];
        newer = line_new[c];
        top = (r == 1) ? newer : older;
        line_old[c] = newer;
        line_new[c] = px;
        push_column(top, newer, px, c == 0);
        if (r >= 1 && c >= 1) emit_filtered(1'b0);
        if (c >= w - 1) begin
          if (r >= 1) begin
            shift_window();
            emit_filtered(1'b0);
          end
          col_pos = 0;
          row_pos = r + 1;
        end else begin
          col_pos = c + 1;
        end
      end
    end else if (row_pos >= h) begin
      // Drain: the bottom row is replicated below the last image row.
      d = drain_pos;
      push_column(line_old[d], line_new[d], line_new[d], d == 0);
      if (d >= 1) emit_filtered(1'b0);
      if (d >= w - 1) begin
        shift_window();
        emit_filtered(1'b1);
        row_pos   = 0;
        col_pos   = 0;
        drain_pos = 0;
      end else begin
        drain_pos = d + 1;
      end
    end
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
  endtask

  // Sender: items change at the falling edge, with a random gap after each.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fired) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        drv_item = stream_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= drv_item.px;
        in_tuser  <= drv_item.op;
        in_gap = in_idle_on ? $urandom_range(0, 10) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall after each result, and two long hold-offs.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_fired) begin
        if (results_seen == HOLD_EARLY || results_seen == hold_mark) hold_left = LONG_HOLD;
        else out_stall = out_idle_on ? $urandom_range(0, 10) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every accepted item, check every accepted result.
  always @(posedge clk) begin
    filtered_t want;
    in_fired  <= rst_n && in_tvalid && in_tready;
    out_fired <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      filter_item(op_t'(in_tuser[0]), pix_t'(in_tdata));
      items_in++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (filtered_q.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                $signed(out_tdata[RES_W-1:0])));
      end else begin
        want = filtered_q.pop_front();
        if (out_tdata[RES_W-1:0] !== want.value)
          flag_mismatch($sformatf("result #%0d value %0d, expected %0d", results_seen,
                                  $signed(out_tdata[RES_W-1:0]), $signed(want.value)));
        if (out_tlast !== want.is_last)
          flag_mismatch($sformatf("result #%0d tlast %b, expected %b", results_seen,
                                  out_tlast, want.is_last));
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               filtered_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Wait until every queued item is taken and every expected result is in,
  // then allow for items still inside the block that release nothing.
  task automatic wait_quiet();
    while (stream_q.size() != 0 || in_tvalid || filtered_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_COEF_TOP: coef_row[0] = val[ROW_W-1:0];
      CFG_COEF_MID: coef_row[1] = val[ROW_W-1:0];
      CFG_COEF_BOT: coef_row[2] = val[ROW_W-1:0];
      CFG_WIDTH:    width_reg   = val[SIZE_W-1:0];
      CFG_HEIGHT:   height_reg  = val[SIZE_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One mask row: extremes, zero, small values within +-1.0 or plain random.
  function automatic logic [ROW_W-1:0] rand_mask_row();
    logic [ROW_W-1:0] row;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 7))
        0:       row[16*k +: 16] = 16'h8000;
        1:       row[16*k +: 16] = 16'h7FFF;
        2:       row[16*k +: 16] = 16'h0000;
        3, 4:    row[16*k +: 16] = 16'($urandom_range(0, 8192)) - 16'd4096;
        default: row[16*k +: 16] = 16'($urandom);
      endcase
    end
    return row;
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 9))
      0:       return pix_t'(16'h8000);
      1:       return pix_t'(16'h7FFF);
      2:       return pix_t'($urandom_range(0, 64)) - pix_t'(32);
      default: return pix_t'($urandom);
    endcase
  endfunction

  // Queue image pixels; a noisy stream slips in early drains, which the
  // block ignores before the final row.
  function automatic void queue_pixels(int n, bit noisy);
    item_t it;
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 40) == 0) begin
        it.op = OP_DRAIN;
        it.px = pix_t'($urandom);
        stream_q.push_back(it);
      end
      it.op = OP_PIXEL;
      it.px = rand_pixel();
      stream_q.push_back(it);
      random_items++;
    end
  endfunction

  function automatic void queue_drains(int n);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it.op = OP_DRAIN;
      it.px = pix_t'($urandom);
      stream_q.push_back(it);
      random_items++;
    end
  endfunction

  // Complete the image in progress from the mirrored positions (block idle).
  function automatic void finish_image();
    int unsigned w, h, r, c;
    w = eff_size(width_reg, MAX_WIDTH_DEF);
    h = eff_size(height_reg, MAX_HEIGHT_DEF);
    c = (col_pos > w - 1) ? w - 1 : col_pos;
    r = (row_pos > h) ? h : row_pos;
    if (r < h) queue_pixels((h - r) * w - c, 1'b1);
    queue_drains(w);
  endfunction

  task automatic configure_image(logic [SIZE_W-1:0] wr, logic [SIZE_W-1:0] hr);
    write_reg(CFG_COEF_TOP, rand_mask_row());
    write_reg(CFG_COEF_MID, rand_mask_row());
    write_reg(CFG_COEF_BOT, rand_mask_row());
    write_reg(CFG_WIDTH, CFG_DATA_W'(wr));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(hr));
  endtask

  initial begin
    item_t       it;
    pix_t        corner_px [9];
    int unsigned w, h, k;

    // Mirror of the reset state.
    coef_row[0] = COEF_TOP_RST;
    coef_row[1] = COEF_MID_RST;
    coef_row[2] = COEF_BOT_RST;
    width_reg   = WIDTH_RST;
    height_reg  = HEIGHT_RST;
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    end
    row_pos   = 0;
    col_pos   = 0;
    drain_pos = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Identity mask from reset, sizes below three acting as 3x3.
    // A drain before the final row and a pixel after it are both ignored.
    write_reg(CFG_WIDTH, CFG_DATA_W'(0));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(2));
    corner_px = '{pix_t'(16'h7FFF), pix_t'(16'h8000), pix_t'(0), pix_t'(1), pix_t'(-1),
                  pix_t'(16'h5555), pix_t'(16'hAAAA), pix_t'(16'h7FFF), pix_t'(16'h8000)};
    it.op = OP_DRAIN;
    it.px = pix_t'(16'hFFFF);
    stream_q.push_back(it);
    for (int i = 0; i < 9; i++) begin
      it.op = OP_PIXEL;
      it.px = corner_px[i];
      stream_q.push_back(it);
    end
    it.px = pix_t'(16'h1234);
    stream_q.push_back(it);
    for (int i = 0; i < 3; i++) begin
      it.op = OP_DRAIN;
      it.px = pix_t'(0);
      stream_q.push_back(it);
    end
    images_sent++;
    wait_quiet();

    // Most negative coefficients on most negative pixels: the largest sum.
    write_reg(CFG_COEF_TOP, 48'h8000_8000_8000);
    write_reg(CFG_COEF_MID, 48'h8000_8000_8000);
    write_reg(CFG_COEF_BOT, 48'h8000_8000_8000);
    for (int i = 0; i < 12; i++) begin
      it.op = (i < 9) ? OP_PIXEL : OP_DRAIN;
      it.px = pix_t'(16'h8000);
      stream_q.push_back(it);
    end
    images_sent++;
    safe_width = 3;
    random_items = 0;

    // Random images of small sizes; some change size halfway through.
    while (random_items < RANDOM_ITEMS) begin
      if (images_sent == 2 || $urandom_range(0, 2) != 0) begin
        wait_quiet();
        configure_image(SIZE_W'($urandom_range(0, 12)), SIZE_W'($urandom_range(1, 6)));
        in_idle_on  = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
      end
      w = eff_size(width_reg, MAX_WIDTH_DEF);
      h = eff_size(height_reg, MAX_HEIGHT_DEF);
      if ($urandom_range(0, 5) == 0) begin
        // Resize mid-image, never wider than the columns already stored.
        queue_pixels($urandom_range(1, w * h - 1), 1'b1);
        wait_quiet();
        k = (safe_width < 10) ? safe_width : 10;
        write_reg(CFG_WIDTH, CFG_DATA_W'($urandom_range(2, k)));
        write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(2, 6)));
        finish_image();
      end else begin
        queue_pixels(w * h, 1'b1);
        // Pixels after the final row are ignored until the drain.
        if ($urandom_range(0, 4) == 0) begin
          k = $urandom_range(1, 3);
          for (int i = 0; i < k; i++) begin
            it.op = OP_PIXEL;
            it.px = pix_t'($urandom);
            stream_q.push_back(it);
          end
        end
        queue_drains(w);
        if (w > safe_width) safe_width = w;
      end
      images_sent++;
    end

    // Back-pressure image: the receiver holds off early in the image while
    // the sender keeps offering items without gaps, so the block fills up.
    wait_quiet();
    configure_image(SIZE_W'(PRESS_W), SIZE_W'(PRESS_H));
    in_idle_on  = 1'b0;
    out_idle_on = 1'b1;
    hold_mark   = results_seen + PRESS_HOLD_AT;
    queue_pixels(PRESS_W * PRESS_H, 1'b0);
    queue_drains(PRESS_W);
    images_sent++;

    wait_quiet();
    $display("Run: %0d items in, %0d filtered pixels checked, %0d images, %0d register writes.",
             items_in, results_seen, images_sent, cfg_writes);
    $display("Sizes from 3x3 up to 12x6, resized images, border and ignored items, stalls.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/c3rb_pkg.sv
sv/c3rb_ram.sv
sv/c3rb_ctrl.sv
sv/c3rb_win.sv
sv/c3rb_mac.sv
sv/conv3x3_replicate_border_core.sv
sv/c3rb_chk.sv
tb/sv/tb_top.sv
